// ===== rtl/walsh_hadamard_transform_defines.svh =====
// Assertion macros shared by the Walsh-Hadamard transform RTL.
`ifndef WALSH_HADAMARD_TRANSFORM_DEFINES_SVH
`define WALSH_HADAMARD_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on i_clk, off during reset.
`define WHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, clocked on i_clk, off during reset.
`define WHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WHT_ASSERT_IMP(label, ante, cons)
`define WHT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/wht_pkg.sv =====
// Package: widths, types and helpers of the Walsh-Hadamard transform.
package wht_pkg;

    localparam int MAX_LOG_SIZE = 5;
    localparam int SAMPLE_WIDTH = 16;
    localparam int DEPTH        = 1 << MAX_LOG_SIZE;
    localparam int ACC_W        = SAMPLE_WIDTH + MAX_LOG_SIZE;
    localparam int OUT_W        = 22;
    localparam int GAIN_W       = 16;
    localparam int LOG_W        = 3;
    localparam int IDX_W        = MAX_LOG_SIZE;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int PROD_W       = ACC_W + GAIN_W + 1;
    localparam int GAIN_RESET   = 32768;
    localparam int LOG_RESET    = 5;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PASS,
        ST_EMIT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_SIZE = 1'd0,
        REG_GAIN     = 1'd1
    } t_reg_idx;

    // per-cell next-value select
    typedef struct packed {
        logic shift;
        logic take_wrap;
        logic take_diff;
    } t_cell_ctrl;

    // sideband traveling with a coefficient into the scaler
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] pos;
        logic             last;
    } t_emit_tag;

    // log_size clamped to 1..MAX_LOG_SIZE
    function automatic logic [LOG_W-1:0] active_log(input logic [LOG_W-1:0] l);
        logic [LOG_W-1:0] r;
        r = l;
        if (l == '0) begin
            r = LOG_W'(1);
        end else if (l > LOG_W'(MAX_LOG_SIZE)) begin
            r = LOG_W'(MAX_LOG_SIZE);
        end
        return r;
    endfunction

endpackage

// ===== rtl/walsh_hadamard_transform.sv =====
// Top level: streaming Walsh-Hadamard transform on a rotating chain of cells.
//
//  channel   direction  transfer when            payload
//  --------  ---------  -----------------------  ----------------------------------
//  sample    in         start & !busy at edge    i_sample (16b signed)
//  config    in         i_cfg_we at edge         i_cfg_addr, i_cfg_data (16b)
//  result    out        o_strobe, one cycle      o_value, o_position, o_final_res
//
// Timing: a block loads one sample per cycle while busy is low. After the
// sample that completes a block of n = 2^L, busy stays high through L
// rotations of the n-cell chain, one rotation to emit, and the scaler's
// product register. Results appear back to back once the emit rotation
// starts, behind the product and output registers of the scaler.
// Reset (synchronous, active low) empties the load count and loads log_size
// and gain; cell contents are undefined until loaded. Results cannot be
// stalled: each is shown for exactly one cycle.
`include "walsh_hadamard_transform_defines.svh"

module walsh_hadamard_transform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [wht_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic                              i_cfg_we,
    input  logic [wht_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [wht_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_strobe,
    output logic signed [wht_pkg::OUT_W-1:0]  o_value,
    output logic [wht_pkg::IDX_W-1:0]         o_position,
    output logic                              o_final_res
);
    import wht_pkg::*;

    // configuration
    logic [LOG_W-1:0]  r_log_size;
    logic [GAIN_W-1:0] r_gain;

    // control
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_count, n_count;   // samples held in the block
    logic [IDX_W-1:0] r_step,  n_step;    // cycle within a rotation
    logic [LOG_W-1:0] r_stage, n_stage;   // butterfly stage of a pass

    logic [LOG_W-1:0] act;
    logic [IDX_W-1:0] last_idx;           // n - 1
    logic [IDX_W-1:0] span;               // butterfly distance of this stage
    logic             low_half;           // head element is the upper input
    logic             accept;
    logic             scale_busy;

    // chain datapath
    t_acc       cell_q [DEPTH];
    t_cell_ctrl cell_ctrl [DEPTH];
    t_acc       head, partner, sum_v, diff_v, wrap_v, sample_ext;
    t_emit_tag  tag;

    assign act        = active_log(r_log_size);
    assign last_idx   = IDX_W'((32'd1 << act) - 32'd1);
    assign span       = IDX_W'(32'd1 << r_stage);
    assign low_half   = (r_step & span) == '0;
    assign accept     = start && !busy;
    assign sample_ext = ACC_W'(i_sample);

    // head cell holds element r_step, cell[span] its partner
    assign head    = cell_q[0];
    assign partner = cell_q[span];
    assign sum_v   = head + partner;
    assign diff_v  = head - partner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= LOG_W'(LOG_RESET);
            r_gain     <= GAIN_W'(GAIN_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LOG_SIZE: r_log_size <= i_cfg_data[LOG_W-1:0];
                REG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_step  <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_stage <= n_stage;
        end
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_step  = r_step;
        n_stage = r_stage;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (r_count == last_idx) begin
                        n_count = '0;
                        n_step  = '0;
                        n_stage = '0;
                        n_state = ST_PASS;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_PASS: begin
                if (r_step == last_idx) begin
                    n_step = '0;
                    if (r_stage == act - 1'b1) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_step == last_idx) begin
                    n_step  = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: n_state = ST_LOAD;
        endcase
        // a log_size write drops any partly loaded block
        if (i_cfg_we && (i_cfg_addr == REG_LOG_SIZE)) begin
            n_count = '0;
        end
    end

    // outputs: chain controls, wrap value, emit tag
    always_comb begin
        wrap_v   = head;
        tag.vld  = 1'b0;
        tag.pos  = r_step;
        tag.last = (r_step == last_idx);
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctrl[k].shift     = 1'b0;
            cell_ctrl[k].take_wrap = (IDX_W'(k) == last_idx);
            cell_ctrl[k].take_diff = 1'b0;
        end
        case (r_state)
            ST_LOAD: begin
                wrap_v = sample_ext;
                for (int k = 0; k < DEPTH; k++) begin
                    cell_ctrl[k].shift = accept;
                end
            end
            ST_PASS: begin
                // upper input: a+b wraps to the tail, a-b replaces the partner
                wrap_v = low_half ? sum_v : head;
                for (int k = 0; k < DEPTH; k++) begin
                    cell_ctrl[k].shift     = 1'b1;
                    cell_ctrl[k].take_diff = low_half && (IDX_W'(k) == span - 1'b1);
                end
            end
            ST_EMIT: begin
                tag.vld = 1'b1;
                for (int k = 0; k < DEPTH; k++) begin
                    cell_ctrl[k].shift = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy = (r_state != ST_LOAD) || scale_busy;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_acc neighbor;
        if (k == DEPTH - 1) begin : g_end
            assign neighbor = '0;
        end else begin : g_mid
            assign neighbor = cell_q[k+1];
        end
        wht_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl[k]),
            .i_neighbor (neighbor),
            .i_wrap     (wrap_v),
            .i_diff     (diff_v),
            .o_value    (cell_q[k])
        );
    end

    wht_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_tag       (tag),
        .i_value     (head),
        .o_busy      (scale_busy),
        .o_strobe    (o_strobe),
        .o_value     (o_value),
        .o_position  (o_position),
        .o_final_res (o_final_res)
    );

    `WHT_ASSERT_IMP(a_strobe_after_busy, o_strobe, $past(busy))
    `WHT_ASSERT_IMP(a_final_has_strobe, o_final_res, o_strobe)
    `WHT_ASSERT_NXT(a_block_starts_pass, accept && (r_count == last_idx), r_state == ST_PASS)
    `WHT_ASSERT_NXT(a_emit_returns_load, (r_state == ST_EMIT) && (r_step == last_idx), r_state == ST_LOAD)
    `WHT_ASSERT_NXT(a_final_ends_burst, o_final_res, !o_strobe)

endmodule

// ===== rtl/wht_cell.sv =====
// One storage cell of the rotating work chain.
module wht_cell (
    input  logic                i_clk,
    input  wht_pkg::t_cell_ctrl i_ctrl,
    input  wht_pkg::t_acc       i_neighbor,
    input  wht_pkg::t_acc       i_wrap,
    input  wht_pkg::t_acc       i_diff,
    output wht_pkg::t_acc       o_value
);
    import wht_pkg::*;

    t_acc r_value;
    t_acc n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift) begin
            if (i_ctrl.take_wrap) begin
                n_value = i_wrap;
            end else if (i_ctrl.take_diff) begin
                n_value = i_diff;
            end else begin
                n_value = i_neighbor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/wht_scale.sv =====
// Output scaler: gain multiply, round half up, shift and saturate.
module wht_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wht_pkg::GAIN_W-1:0]    i_gain,
    input  wht_pkg::t_emit_tag            i_tag,
    input  wht_pkg::t_acc                 i_value,
    output logic                          o_busy,
    output logic                          o_strobe,
    output logic signed [wht_pkg::OUT_W-1:0] o_value,
    output logic [wht_pkg::IDX_W-1:0]     o_position,
    output logic                          o_final_res
);
    import wht_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1 << 14);
    localparam logic signed [PROD_W-1:0] VMAX  = PROD_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] VMIN  = -PROD_W'(1 << (OUT_W - 1));

    logic signed [PROD_W-1:0] r_prod;
    t_emit_tag                r_tag;
    logic signed [PROD_W-1:0] sh;
    logic signed [OUT_W-1:0]  sat;
    logic signed [OUT_W-1:0]  r_out;
    logic [IDX_W-1:0]         r_pos;
    logic                     r_last;
    logic                     r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_tag.vld <= i_tag.vld;
            r_strobe  <= r_tag.vld;
        end
        r_prod     <= PROD_W'(i_value) * $signed({1'b0, i_gain});
        r_tag.pos  <= i_tag.pos;
        r_tag.last <= i_tag.last;
        r_out      <= sat;
        r_pos      <= r_tag.pos;
        r_last     <= r_tag.last;
    end

    // floor shift of the biased product
    always_comb begin
        sh = (r_prod + ROUND) >>> 15;
        if (sh > VMAX) begin
            sat = VMAX[OUT_W-1:0];
        end else if (sh < VMIN) begin
            sat = VMIN[OUT_W-1:0];
        end else begin
            sat = sh[OUT_W-1:0];
        end
    end

    assign o_busy      = r_tag.vld;
    assign o_strobe    = r_strobe;
    assign o_value     = r_out;
    assign o_position  = r_pos;
    assign o_final_res = r_last & r_strobe;

endmodule
